### rtl/ilss_pkg.sv
`timescale 1ns / 1ps

package ilss_pkg;

  // Default store depth
  localparam int unsigned DEPTH_DEF = 64;

  // Field widths
  localparam int unsigned OP_W  = 3;
  localparam int unsigned POS_W = 6;
  localparam int unsigned LET_W = 8;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned CNT_W = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH  = 3'd3;
  localparam logic [OP_W-1:0] OP_REVERSE = 3'd4;
  localparam logic [OP_W-1:0] OP_GET     = 3'd5;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture request, set up pointers
    logic step;      // one shift/scan step
    logic fin;       // final write and count update
    logic rd_lo;     // read at low pointer
    logic rd_hi;     // read at high pointer, keep low data
    logic wr_lo;     // write high data at low pointer
    logic wr_hi;     // write low data at high pointer, advance, read next low
    logic out_load;  // load result register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic err;       // request fails its checks
    logic multi;     // more than one letter stored
    logic busy;      // shift/scan still has work
    logic match;     // scan hit on the current entry
    logic rev_more;  // another swap pair remains
  } sts_t;

endpackage

### rtl/ilss_req_if.sv
`timescale 1ns / 1ps

interface ilss_req_if;
  logic                         valid;
  logic                         ready;
  logic [ilss_pkg::OP_W-1:0]    operation;
  logic [ilss_pkg::POS_W-1:0]   position;
  logic [ilss_pkg::LET_W-1:0]   letter_in;

  modport source (output valid, output operation, output position, output letter_in,
                  input ready);
  modport sink   (input valid, input operation, input position, input letter_in,
                  output ready);
endinterface

### rtl/ilss_rsp_if.sv
`timescale 1ns / 1ps

interface ilss_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ilss_pkg::ST_W-1:0]    status;
  logic [ilss_pkg::LET_W-1:0]   letter_out;
  logic                         found;
  logic [ilss_pkg::POS_W-1:0]   found_position;
  logic [ilss_pkg::CNT_W-1:0]   count;

  modport source (output valid, output status, output letter_out, output found,
                  output found_position, output count, input ready);
  modport sink   (input valid, input status, input letter_out, input found,
                  input found_position, input count, output ready);
endinterface

### rtl/ilss_ctrl.sv
`timescale 1ns / 1ps

module ilss_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [ilss_pkg::OP_W-1:0] in_op_i,
  input  logic                      out_ready_i,
  input  ilss_pkg::sts_t            sts_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  output ilss_pkg::cmd_t            cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SHIFT = 4'd1;
  localparam logic [3:0] S_FIN   = 4'd2;
  localparam logic [3:0] S_GET   = 4'd3;
  localparam logic [3:0] S_REV_A = 4'd4;
  localparam logic [3:0] S_REV_B = 4'd5;
  localparam logic [3:0] S_REV_C = 4'd6;
  localparam logic [3:0] S_REV_D = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.err) begin
            state_d = S_DONE;
          end else begin
            case (in_op_i)
              ilss_pkg::OP_APPEND:  state_d = S_FIN;
              ilss_pkg::OP_INSERT,
              ilss_pkg::OP_REMOVE,
              ilss_pkg::OP_SEARCH:  state_d = S_SHIFT;
              ilss_pkg::OP_REVERSE: state_d = sts_i.multi ? S_REV_A : S_DONE;
              ilss_pkg::OP_GET:     state_d = S_GET;
              default:              state_d = S_DONE;
            endcase
          end
        end
      end
      S_SHIFT: begin
        cmd_o.step = 1'b1;
        if (sts_i.match) begin
          state_d = S_DONE;
        end else if (!sts_i.busy) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_DONE;
      end
      S_GET: begin
        cmd_o.rd_lo = 1'b1;
        state_d     = S_DONE;
      end
      S_REV_A: begin
        cmd_o.rd_lo = 1'b1;
        state_d     = S_REV_B;
      end
      S_REV_B: begin
        cmd_o.rd_hi = 1'b1;
        state_d     = S_REV_C;
      end
      S_REV_C: begin
        cmd_o.wr_lo = 1'b1;
        state_d     = S_REV_D;
      end
      S_REV_D: begin
        cmd_o.wr_hi = 1'b1;
        state_d     = sts_i.rev_more ? S_REV_B : S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result slot
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A finished item waits while the result slot is still taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_ready_i) |=> (state_q == S_DONE))
    else $error("finished item left DONE while result slot was busy");

endmodule

### rtl/ilss_dpath.sv
`timescale 1ns / 1ps

module ilss_dpath #(
  parameter int unsigned DEPTH = ilss_pkg::DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ilss_pkg::cmd_t              cmd_i,
  input  logic [ilss_pkg::OP_W-1:0]   in_op_i,
  input  logic [ilss_pkg::POS_W-1:0]  in_pos_i,
  input  logic [ilss_pkg::LET_W-1:0]  in_letter_i,
  output ilss_pkg::sts_t              sts_o,
  output logic [ilss_pkg::ST_W-1:0]   status_o,
  output logic [ilss_pkg::LET_W-1:0]  letter_o,
  output logic                        found_o,
  output logic [ilss_pkg::POS_W-1:0]  found_pos_o,
  output logic [ilss_pkg::CNT_W-1:0]  count_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > ilss_pkg::POS_W) ? CW : ilss_pkg::POS_W;
  localparam int unsigned LW   = ilss_pkg::LET_W;

  // Letter memory
  logic [LW-1:0] mem [DEPTH];
  logic [LW-1:0] rdata_q;
  logic          re, we;
  logic [AW-1:0] ra, wa;
  logic [LW-1:0] wd;

  // Request and control state
  logic [ilss_pkg::OP_W-1:0]  op_q;
  logic [LW-1:0]              let_q;
  logic [ilss_pkg::ST_W-1:0]  st_q;
  logic [AW-1:0]              pos_q;
  logic [CW-1:0]              cnt_q;
  logic [CW-1:0]              rem_q;
  logic [AW-1:0]              ptr_q, hi_q, wa_q;
  logic                       wv_q;
  logic [LW-1:0]              tmp_q;
  logic                       found_q;
  logic [ilss_pkg::POS_W-1:0] fpos_q;

  // Result register
  logic [ilss_pkg::ST_W-1:0]  res_status_q;
  logic [LW-1:0]              res_letter_q;
  logic                       res_found_q;
  logic [ilss_pkg::POS_W-1:0] res_fpos_q;
  logic [ilss_pkg::CNT_W-1:0] res_count_q;

  logic                      full, empty, oor;
  logic [ilss_pkg::ST_W-1:0] in_st;
  logic [AW-1:0]             pos_eff;
  logic                      step_rd, step_wr, fin_wr;

  // Checks on the incoming request
  always_comb begin
    full    = (cnt_q == CW'(DEPTH));
    empty   = (cnt_q == '0);
    oor     = (CMPW'(in_pos_i) >= CMPW'(cnt_q));
    pos_eff = empty ? '0 : AW'(in_pos_i);
    case (in_op_i)
      ilss_pkg::OP_APPEND: in_st = full ? ilss_pkg::ST_FULL : ilss_pkg::ST_OK;
      ilss_pkg::OP_INSERT: begin
        if (full) begin
          in_st = ilss_pkg::ST_FULL;
        end else if (!empty && oor) begin
          in_st = ilss_pkg::ST_RANGE;
        end else begin
          in_st = ilss_pkg::ST_OK;
        end
      end
      ilss_pkg::OP_REMOVE,
      ilss_pkg::OP_GET:    in_st = oor ? ilss_pkg::ST_RANGE : ilss_pkg::ST_OK;
      default:             in_st = ilss_pkg::ST_OK;
    endcase
  end

  assign sts_o.err      = (in_st != ilss_pkg::ST_OK);
  assign sts_o.multi    = (cnt_q > CW'(1));
  assign sts_o.busy     = (rem_q != '0) || wv_q;
  assign sts_o.match    = wv_q && (op_q == ilss_pkg::OP_SEARCH) && (rdata_q == let_q);
  assign sts_o.rev_more = ((ptr_q + AW'(1)) < (hi_q - AW'(1)));

  // Memory port selection
  assign step_rd = cmd_i.step && (rem_q != '0);
  assign step_wr = cmd_i.step && wv_q &&
                   ((op_q == ilss_pkg::OP_INSERT) || (op_q == ilss_pkg::OP_REMOVE));
  assign fin_wr  = cmd_i.fin && (st_q == ilss_pkg::ST_OK) &&
                   ((op_q == ilss_pkg::OP_APPEND) || (op_q == ilss_pkg::OP_INSERT));

  always_comb begin
    re = step_rd || cmd_i.rd_lo || cmd_i.rd_hi || cmd_i.wr_hi;
    if (cmd_i.rd_hi) begin
      ra = hi_q;
    end else if (cmd_i.wr_hi) begin
      ra = ptr_q + AW'(1);
    end else begin
      ra = ptr_q;
    end

    we = step_wr || fin_wr || cmd_i.wr_lo || cmd_i.wr_hi;
    wa = wa_q;
    wd = rdata_q;
    if (cmd_i.wr_lo) begin
      wa = ptr_q;
    end else if (cmd_i.wr_hi) begin
      wa = hi_q;
      wd = tmp_q;
    end else if (fin_wr) begin
      wa = (op_q == ilss_pkg::OP_APPEND) ? AW'(cnt_q) : pos_q;
      wd = let_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_q <= mem[ra];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      rem_q   <= '0;
      wv_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        wv_q    <= 1'b0;
        found_q <= 1'b0;
        case (in_op_i)
          ilss_pkg::OP_INSERT: rem_q <= cnt_q - CW'(pos_eff);
          ilss_pkg::OP_REMOVE: rem_q <= cnt_q - CW'(1) - CW'(in_pos_i);
          ilss_pkg::OP_SEARCH: rem_q <= cnt_q;
          default:             rem_q <= '0;
        endcase
      end else if (cmd_i.step) begin
        wv_q <= step_rd;
        if (step_rd) begin
          rem_q <= rem_q - CW'(1);
        end
        if (sts_o.match) begin
          found_q <= 1'b1;
        end
      end
      // Count update at the end of a successful edit
      if (cmd_i.fin && (st_q == ilss_pkg::ST_OK)) begin
        if ((op_q == ilss_pkg::OP_APPEND) || (op_q == ilss_pkg::OP_INSERT)) begin
          cnt_q <= cnt_q + CW'(1);
        end else if (op_q == ilss_pkg::OP_REMOVE) begin
          cnt_q <= cnt_q - CW'(1);
        end
      end
    end
  end

  // Request capture and pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_op_i;
      let_q  <= in_letter_i;
      st_q   <= in_st;
      pos_q  <= pos_eff;
      fpos_q <= '0;
      hi_q   <= AW'(cnt_q - CW'(1));
      case (in_op_i)
        ilss_pkg::OP_INSERT: ptr_q <= AW'(cnt_q - CW'(1));
        ilss_pkg::OP_REMOVE: ptr_q <= AW'(in_pos_i) + AW'(1);
        ilss_pkg::OP_GET:    ptr_q <= AW'(in_pos_i);
        default:             ptr_q <= '0;
      endcase
    end else begin
      if (step_rd) begin
        case (op_q)
          ilss_pkg::OP_INSERT: begin
            ptr_q <= ptr_q - AW'(1);
            wa_q  <= ptr_q + AW'(1);
          end
          ilss_pkg::OP_REMOVE: begin
            ptr_q <= ptr_q + AW'(1);
            wa_q  <= ptr_q - AW'(1);
          end
          default: begin
            ptr_q <= ptr_q + AW'(1);
            wa_q  <= ptr_q;
          end
        endcase
      end
      if (cmd_i.step && sts_o.match && !found_q) begin
        fpos_q <= ilss_pkg::POS_W'(wa_q);
      end
      if (cmd_i.rd_hi) begin
        tmp_q <= rdata_q;
      end
      if (cmd_i.wr_hi) begin
        ptr_q <= ptr_q + AW'(1);
        hi_q  <= hi_q - AW'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_status_q <= st_q;
      res_letter_q <= ((op_q == ilss_pkg::OP_GET) && (st_q == ilss_pkg::ST_OK)) ?
                      rdata_q : '0;
      res_found_q  <= found_q;
      res_fpos_q   <= found_q ? fpos_q : '0;
      res_count_q  <= ilss_pkg::CNT_W'(cnt_q);
    end
  end

  assign status_o    = res_status_q;
  assign letter_o    = res_letter_q;
  assign found_o     = res_found_q;
  assign found_pos_o = res_fpos_q;
  assign count_o     = res_count_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("letter count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fin && (st_q == ilss_pkg::ST_OK) &&
     ((op_q == ilss_pkg::OP_APPEND) || (op_q == ilss_pkg::OP_INSERT)))
    |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("count did not grow after a successful append or insert");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_hi |-> ((CW'(hi_q) < cnt_q) && (ptr_q < hi_q)))
    else $error("reverse swap outside the stored letters");

endmodule

### rtl/indexed_letter_sequence_store.sv
`timescale 1ns / 1ps
// Transaction flow, accept to result valid (plus any result stall): a refused request, an
//   unused code or a reverse of fewer than two letters goes straight to the result; append
//   writes the letter and get reads it; insert and remove shift the letters after the position
//   one at a time; search scans from index 0 and stops at the first hit; reverse swaps pairs
//   from both ends. One transaction in flight: the controller takes a request only when idle.
// Reset clears the count and the controller; the letter memory is not cleared.

module indexed_letter_sequence_store #(
  parameter int unsigned DEPTH = ilss_pkg::DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ilss_req_if.sink          req_i,
  ilss_rsp_if.source        rsp_o
);

  ilss_pkg::cmd_t cmd;
  ilss_pkg::sts_t sts;
  logic           in_ready;
  logic           out_valid;

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;

  ilss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_op_i     (req_i.operation),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  ilss_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_op_i     (req_i.operation),
    .in_pos_i    (req_i.position),
    .in_letter_i (req_i.letter_in),
    .sts_o       (sts),
    .status_o    (rsp_o.status),
    .letter_o    (rsp_o.letter_out),
    .found_o     (rsp_o.found),
    .found_pos_o (rsp_o.found_position),
    .count_o     (rsp_o.count)
  );

endmodule

### bench/letter_store_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts each response from the request stream
// and compares field by field against the oldest prediction.
module letter_store_checker (
  input  logic clk_i,
  input  logic rst_ni,
  ilss_req_if  req_mon,
  ilss_rsp_if  rsp_mon,
  output int   mismatch_count_o,
  output int   pending_o
);

  localparam int unsigned STORE_DEPTH = ilss_pkg::DEPTH_DEF;

  typedef struct packed {
    logic [ilss_pkg::ST_W-1:0]  status;
    logic [ilss_pkg::LET_W-1:0] letter_out;
    logic                       found;
    logic [ilss_pkg::POS_W-1:0] found_position;
    logic [ilss_pkg::CNT_W-1:0] count;
  } seq_rsp_t;

  // Shadow copy of the letter sequence
  logic [ilss_pkg::LET_W-1:0] seq_mem [STORE_DEPTH];
  int                         seq_len;

  seq_rsp_t awaited_rsp_q [$];
  int       mismatches;
  int       pending_cnt;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending_cnt;

  task automatic report_mismatch(input string field, input int exp_v, input int got_v);
    $display("%0t ns: response mismatch on %s, expected %0d, got %0d",
             $realtime, field, exp_v, got_v);
    mismatches++;
  endtask

  // Apply one request transaction to the shadow store and build its response
  task automatic predict_letter_op(input logic [ilss_pkg::OP_W-1:0] op,
                                   input logic [ilss_pkg::POS_W-1:0] pos,
                                   input logic [ilss_pkg::LET_W-1:0] ltr,
                                   output seq_rsp_t r);
    int                         n;
    int                         i;
    int                         p;
    int                         lo;
    int                         hi;
    logic [ilss_pkg::LET_W-1:0] tmp;
    n = seq_len;
    r = '0;
    case (op)
      ilss_pkg::OP_APPEND: begin
        if (n >= STORE_DEPTH) begin
          r.status = ilss_pkg::ST_FULL;
        end else begin
          seq_mem[n] = ltr;
          seq_len = n + 1;
        end
      end
      ilss_pkg::OP_INSERT: begin
        // full check ahead of the range check; empty store always lands at 0
        if (n >= STORE_DEPTH) begin
          r.status = ilss_pkg::ST_FULL;
        end else if (n != 0 && int'(pos) >= n) begin
          r.status = ilss_pkg::ST_RANGE;
        end else begin
          p = (n == 0) ? 0 : int'(pos);
          for (i = n; i > p; i--) seq_mem[i] = seq_mem[i-1];
          seq_mem[p] = ltr;
          seq_len = n + 1;
        end
      end
      ilss_pkg::OP_REMOVE: begin
        if (int'(pos) >= n) begin
          r.status = ilss_pkg::ST_RANGE;
        end else begin
          for (i = int'(pos); i + 1 < n; i++) seq_mem[i] = seq_mem[i+1];
          seq_len = n - 1;
        end
      end
      ilss_pkg::OP_SEARCH: begin
        for (i = 0; i < n; i++) begin
          if (!r.found && seq_mem[i] == ltr) begin
            r.found = 1'b1;
            r.found_position = ilss_pkg::POS_W'(i);
          end
        end
      end
      ilss_pkg::OP_REVERSE: begin
        lo = 0;
        hi = n - 1;
        while (lo < hi) begin
          tmp = seq_mem[lo];
          seq_mem[lo] = seq_mem[hi];
          seq_mem[hi] = tmp;
          lo++;
          hi--;
        end
      end
      ilss_pkg::OP_GET: begin
        if (int'(pos) >= n) r.status = ilss_pkg::ST_RANGE;
        else r.letter_out = seq_mem[pos];
      end
      default: ;
    endcase
    r.count = ilss_pkg::CNT_W'(seq_len);
  endtask

  // Request side pushes first so a same-edge response still pops the oldest
  always @(posedge clk_i or negedge rst_ni) begin
    seq_rsp_t exp_r;
    seq_rsp_t got_r;
    if (!rst_ni) begin
      awaited_rsp_q.delete();
      seq_len     = 0;
      mismatches  = 0;
      pending_cnt <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        predict_letter_op(req_mon.operation, req_mon.position, req_mon.letter_in, exp_r);
        awaited_rsp_q.push_back(exp_r);
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got_r.status         = rsp_mon.status;
        got_r.letter_out     = rsp_mon.letter_out;
        got_r.found          = rsp_mon.found;
        got_r.found_position = rsp_mon.found_position;
        got_r.count          = rsp_mon.count;
        if (awaited_rsp_q.size() == 0) begin
          report_mismatch("unexpected response, status", -1, int'(got_r.status));
        end else begin
          exp_r = awaited_rsp_q.pop_front();
          if (got_r.status !== exp_r.status)
            report_mismatch("status", int'(exp_r.status), int'(got_r.status));
          if (got_r.letter_out !== exp_r.letter_out)
            report_mismatch("letter_out", int'(exp_r.letter_out), int'(got_r.letter_out));
          if (got_r.found !== exp_r.found)
            report_mismatch("found", int'(exp_r.found), int'(got_r.found));
          if (got_r.found_position !== exp_r.found_position)
            report_mismatch("found_position", int'(exp_r.found_position),
                            int'(got_r.found_position));
          if (got_r.count !== exp_r.count)
            report_mismatch("count", int'(exp_r.count), int'(got_r.count));
        end
      end
      pending_cnt <= awaited_rsp_q.size();
    end
  end

endmodule

### bench/tb_indexed_letter_sequence_store.sv
`timescale 1ns / 1ps

module tb_indexed_letter_sequence_store;

  localparam int RAND_ITEMS   = 1700;
  localparam int QUIET_FROM   = RAND_ITEMS * 85 / 100;
  localparam int DRAIN_CYCLES = 3 * ilss_pkg::DEPTH_DEF / 2 + 40;

  // Codes the block treats as no-ops
  localparam logic [ilss_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [ilss_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_ANY} op_mix_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  ilss_req_if req ();
  ilss_rsp_if rsp ();

  int mismatches;
  int pending;
  int seen_count;
  int rsp_stall;
  bit idle_en;

  indexed_letter_sequence_store #(.DEPTH(ilss_pkg::DEPTH_DEF)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  letter_store_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_mon          (req),
    .rsp_mon          (rsp),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Response side: random stall bursts, last seen count kept for biasing positions
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp.valid && rsp.ready) seen_count <= int'(rsp.count);
      if (rsp_stall > 0) begin
        rsp_stall <= rsp_stall - 1;
        rsp.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 11) == 0) begin
        rsp_stall <= $urandom_range(0, 14);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // One request transaction, with an optional idle burst ahead of it
  task automatic send_req(input logic [ilss_pkg::OP_W-1:0] op,
                          input logic [ilss_pkg::POS_W-1:0] pos,
                          input logic [ilss_pkg::LET_W-1:0] ltr);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.position  <= pos;
    req.letter_in <= ltr;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  // Mostly a small alphabet so searches hit
  function automatic logic [ilss_pkg::LET_W-1:0] pick_letter();
    if ($urandom_range(0, 3) != 0) return ilss_pkg::LET_W'(8'h41 + $urandom_range(0, 5));
    return ilss_pkg::LET_W'($urandom_range(0, 255));
  endfunction

  // Mostly in range, some at the count boundary, some anywhere
  function automatic logic [ilss_pkg::POS_W-1:0] pick_pos();
    int roll;
    roll = $urandom_range(0, 9);
    if (seen_count == 0 || roll == 0) return ilss_pkg::POS_W'($urandom_range(0, 63));
    if (roll == 1) return ilss_pkg::POS_W'((seen_count > 63) ? 63 : seen_count);
    return ilss_pkg::POS_W'($urandom_range(0, seen_count - 1));
  endfunction

  function automatic logic [ilss_pkg::OP_W-1:0] pick_op(input op_mix_e mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (roll < 50) return ilss_pkg::OP_APPEND;
        if (roll < 88) return ilss_pkg::OP_INSERT;
        if (roll < 92) return ilss_pkg::OP_SEARCH;
        if (roll < 95) return ilss_pkg::OP_GET;
        if (roll < 97) return ilss_pkg::OP_REMOVE;
        if (roll < 99) return ilss_pkg::OP_REVERSE;
        return OP_RSVD6;
      end
      MIX_SHRINK: begin
        if (roll < 45) return ilss_pkg::OP_REMOVE;
        if (roll < 60) return ilss_pkg::OP_SEARCH;
        if (roll < 75) return ilss_pkg::OP_GET;
        if (roll < 85) return ilss_pkg::OP_REVERSE;
        if (roll < 92) return ilss_pkg::OP_APPEND;
        if (roll < 98) return ilss_pkg::OP_INSERT;
        return OP_RSVD7;
      end
      default: begin
        if (roll < 98) begin
          return ilss_pkg::OP_W'($urandom_range(int'(ilss_pkg::OP_APPEND),
                                                int'(ilss_pkg::OP_GET)));
        end
        return roll[0] ? OP_RSVD6 : OP_RSVD7;
      end
    endcase
  endfunction

  initial begin
    op_mix_e mix;
    int      sent;
    int      seg_len;
    int      k;
    bit      first_seg;

    rst_ni        = 1'b0;
    req.valid     = 1'b0;
    req.operation = ilss_pkg::OP_APPEND;
    req.position  = '0;
    req.letter_in = '0;
    rsp.ready     = 1'b0;
    seen_count    = 0;
    rsp_stall     = 0;
    idle_en       = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty store, single letter, boundaries, no-op codes
    send_req(ilss_pkg::OP_GET,     6'd0,  8'h00);
    send_req(ilss_pkg::OP_REMOVE,  6'd0,  8'h00);
    send_req(ilss_pkg::OP_SEARCH,  6'd0,  8'h41);
    send_req(ilss_pkg::OP_REVERSE, 6'd0,  8'h00);
    send_req(ilss_pkg::OP_INSERT,  6'd63, 8'h5A);   // empty store: goes to position 0
    send_req(ilss_pkg::OP_REVERSE, 6'd0,  8'h00);   // one letter
    send_req(ilss_pkg::OP_GET,     6'd0,  8'h00);
    send_req(ilss_pkg::OP_INSERT,  6'd1,  8'h11);   // position equal to count is refused
    send_req(ilss_pkg::OP_APPEND,  6'd0,  8'hFF);
    send_req(ilss_pkg::OP_APPEND,  6'd63, 8'h00);
    send_req(ilss_pkg::OP_INSERT,  6'd0,  8'h42);
    send_req(ilss_pkg::OP_INSERT,  6'd2,  8'h43);
    send_req(ilss_pkg::OP_SEARCH,  6'd0,  8'h00);
    send_req(ilss_pkg::OP_SEARCH,  6'd0,  8'h7E);   // miss
    send_req(ilss_pkg::OP_SEARCH,  6'd63, 8'h42);
    send_req(ilss_pkg::OP_REVERSE, 6'd0,  8'h00);
    send_req(ilss_pkg::OP_GET,     6'd63, 8'h00);
    send_req(ilss_pkg::OP_GET,     6'd4,  8'h00);
    send_req(ilss_pkg::OP_REMOVE,  6'd4,  8'h00);
    send_req(ilss_pkg::OP_REMOVE,  6'd0,  8'h00);
    send_req(ilss_pkg::OP_REMOVE,  6'd7,  8'h00);
    send_req(OP_RSVD6,             6'd42, 8'h55);
    send_req(OP_RSVD7,             6'd63, 8'hFF);
    send_req(ilss_pkg::OP_APPEND,  6'd21, 8'h80);
    send_req(ilss_pkg::OP_GET,     6'd0,  8'h00);

    // Random: segments that grow, shrink or mix; the first one fills the store
    sent      = 0;
    first_seg = 1'b1;
    while (sent < RAND_ITEMS) begin
      mix       = first_seg ? MIX_GROW : op_mix_e'($urandom_range(0, 2));
      seg_len   = first_seg ? 100 : $urandom_range(40, 160);
      first_seg = 1'b0;
      idle_en   = (sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      for (k = 0; k < seg_len && sent < RAND_ITEMS; k++) begin
        if (sent >= QUIET_FROM) idle_en = 1'b0;
        send_req(pick_op(mix), pick_pos(), pick_letter());
        sent++;
      end
    end
    req.valid <= 1'b0;

    // Drain: wait for every response, then let the block settle
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/ilss_pkg.sv
rtl/ilss_req_if.sv
rtl/ilss_rsp_if.sv
rtl/ilss_ctrl.sv
rtl/ilss_dpath.sv
rtl/indexed_letter_sequence_store.sv
bench/letter_store_checker.sv
bench/tb_indexed_letter_sequence_store.sv
